// File: src/tcw_pkg.sv
// Package for the text console writer: geometry, character and op codes,
// sequencer state and the structs that pass between the sequencer and top level.
// No dependencies.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int TAB_SPACES = 4;
    localparam int TAB_W      = $clog2(TAB_SPACES);

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int CELL_W     = 16;
    localparam int RES_ROW_W  = 5;
    localparam int RES_COL_W  = 7;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [7:0]        ATTR_RESET = 8'h07;

    typedef enum logic [5:0] {
        S_FILL  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_GLYPH = 6'b000100,
        S_COPY  = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        FILL_INIT   = 2'd0,
        FILL_CLEAR  = 2'd1,
        FILL_SCROLL = 2'd2
    } fill_kind_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [RES_ROW_W-1:0] cursor_row;
        logic [RES_COL_W-1:0] cursor_col;
    } result_t;

endpackage

// File: src/tcw_if.sv
// Handshake interfaces of the text console writer: command, response, config.
// Depends on tcw_pkg.
interface tcw_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::OP_W-1:0]     op;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::INDEX_W-1:0]  cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input op, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CELL_W-1:0]    cell_data;
    logic [tcw_pkg::RES_ROW_W-1:0] cursor_row;
    logic [tcw_pkg::RES_COL_W-1:0] cursor_col;

    modport source (output valid, output cell_data, output cursor_row, output cursor_col,
                    input ready);
    modport sink (input valid, input cell_data, input cursor_row, input cursor_col,
                  output ready);
endinterface

interface tcw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/tcw_sequencer.sv
// Sequencer of the text console writer: cursor, line base and the walks for
// fill, scroll and per-glyph writes; a scroll step can read and write the screen store together.
// Depends on tcw_pkg.
module tcw_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcw_pkg::OP_W-1:0]      op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    input  logic [7:0]                    attr,
    input  logic [tcw_pkg::CELL_W-1:0]    rd_data,
    input  logic                          slot_free,
    output logic                          idle,
    output logic                          done,
    output tcw_pkg::result_t              result,
    output tcw_pkg::mem_cmd_t             cmd
);

    tcw_pkg::state_t                  state_reg, state_next;
    tcw_pkg::fill_kind_t              fill_kind_reg, fill_kind_next;
    logic [tcw_pkg::CNT_W-1:0]        addr_reg, addr_next;
    logic                             copy_valid_reg, copy_valid_next;
    logic [tcw_pkg::ADDR_W-1:0]       copy_addr_reg, copy_addr_next;
    logic [tcw_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]        col_reg, col_next;
    logic [tcw_pkg::ADDR_W-1:0]       base_reg, base_next;
    logic [tcw_pkg::TAB_W-1:0]        tab_left_reg, tab_left_next;
    logic                             more_reg, more_next;
    logic [tcw_pkg::CHAR_W-1:0]       glyph_reg, glyph_next;
    logic [tcw_pkg::CELL_W-1:0]       data_reg, data_next;
    logic                             last_col;
    logic                             last_row;
    logic                             more;

    assign last_col = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign last_row = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign more     = (tab_left_reg != '0);

    always_comb
    begin
        state_next      = state_reg;
        fill_kind_next  = fill_kind_reg;
        addr_next       = addr_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        tab_left_next   = tab_left_reg;
        more_next       = more_reg;
        glyph_next      = glyph_reg;
        data_next       = data_reg;
        done            = 1'b0;
        cmd             = '0;

        if (copy_valid_reg)
        begin
            cmd.we    = 1'b1;
            cmd.waddr = copy_addr_reg;
            cmd.wdata = rd_data;
        end

        unique case (state_reg)
            tcw_pkg::S_FILL:
            begin
                cmd.we    = 1'b1;
                cmd.waddr = addr_reg[tcw_pkg::ADDR_W-1:0];
                cmd.wdata = (fill_kind_reg == tcw_pkg::FILL_INIT) ? tcw_pkg::RESET_CELL
                                                                  : {attr, tcw_pkg::CH_SPACE};
                addr_next = addr_reg + tcw_pkg::CNT_W'(1);
                if (addr_reg == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1))
                begin
                    unique case (fill_kind_reg)
                        tcw_pkg::FILL_INIT:
                        begin
                            state_next = tcw_pkg::S_IDLE;
                        end
                        tcw_pkg::FILL_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            state_next = tcw_pkg::S_DONE;
                        end
                        default:
                        begin
                            state_next = more_reg ? tcw_pkg::S_GLYPH : tcw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            tcw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    data_next = '0;
                    unique case (op)
                        tcw_pkg::OP_PUT:
                        begin
                            priority if (char_code == tcw_pkg::CH_NEWLINE)
                            begin
                                col_next  = '0;
                                more_next = 1'b0;
                                if (last_row)
                                begin
                                    addr_next  = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                                    state_next = tcw_pkg::S_COPY;
                                end
                                else
                                begin
                                    row_next   = row_reg + tcw_pkg::ROW_W'(1);
                                    base_next  = base_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                                    state_next = tcw_pkg::S_DONE;
                                end
                            end
                            else if (char_code == tcw_pkg::CH_RETURN)
                            begin
                                col_next   = '0;
                                state_next = tcw_pkg::S_DONE;
                            end
                            else if (char_code == tcw_pkg::CH_TAB)
                            begin
                                glyph_next    = tcw_pkg::CH_SPACE;
                                tab_left_next = tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES - 1);
                                state_next    = tcw_pkg::S_GLYPH;
                            end
                            else
                            begin
                                glyph_next    = char_code;
                                tab_left_next = '0;
                                state_next    = tcw_pkg::S_GLYPH;
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            addr_next      = '0;
                            fill_kind_next = tcw_pkg::FILL_CLEAR;
                            state_next     = tcw_pkg::S_FILL;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (32'(cell_index) < tcw_pkg::CELLS)
                            begin
                                cmd.re     = 1'b1;
                                cmd.raddr  = tcw_pkg::ADDR_W'(cell_index);
                                state_next = tcw_pkg::S_READ;
                            end
                            else
                            begin
                                state_next = tcw_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = tcw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            tcw_pkg::S_GLYPH:
            begin
                cmd.we    = 1'b1;
                cmd.waddr = base_reg + tcw_pkg::ADDR_W'(col_reg);
                cmd.wdata = {attr, glyph_reg};
                if (more)
                begin
                    tab_left_next = tab_left_reg - tcw_pkg::TAB_W'(1);
                end
                more_next  = more;
                state_next = more ? tcw_pkg::S_GLYPH : tcw_pkg::S_DONE;
                if (last_col)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        addr_next  = tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
                        state_next = tcw_pkg::S_COPY;
                    end
                    else
                    begin
                        row_next  = row_reg + tcw_pkg::ROW_W'(1);
                        base_next = base_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                    end
                end
                else
                begin
                    col_next = col_reg + tcw_pkg::COL_W'(1);
                end
            end
            tcw_pkg::S_COPY:
            begin
                if (addr_reg < tcw_pkg::CNT_W'(tcw_pkg::CELLS))
                begin
                    cmd.re          = 1'b1;
                    cmd.raddr       = addr_reg[tcw_pkg::ADDR_W-1:0];
                    copy_valid_next = 1'b1;
                    copy_addr_next  = tcw_pkg::ADDR_W'(addr_reg
                                                        - tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
                    addr_next       = addr_reg + tcw_pkg::CNT_W'(1);
                end
                else if (!copy_valid_reg)
                begin
                    addr_next      = tcw_pkg::CNT_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                    fill_kind_next = tcw_pkg::FILL_SCROLL;
                    state_next     = tcw_pkg::S_FILL;
                end
            end
            tcw_pkg::S_READ:
            begin
                data_next  = rd_data;
                state_next = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = tcw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcw_pkg::S_FILL;
            fill_kind_reg  <= tcw_pkg::FILL_INIT;
            addr_reg       <= '0;
            copy_valid_reg <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            tab_left_reg   <= '0;
            more_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_kind_reg  <= fill_kind_next;
            addr_reg       <= addr_next;
            copy_valid_reg <= copy_valid_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            tab_left_reg   <= tab_left_next;
            more_reg       <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        glyph_reg     <= glyph_next;
        data_reg      <= data_next;
    end

    assign idle              = (state_reg == tcw_pkg::S_IDLE);
    assign result.cell_data  = data_reg;
    assign result.cursor_row = tcw_pkg::RES_ROW_W'(row_reg);
    assign result.cursor_col = tcw_pkg::RES_COL_W'(col_reg);

    a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_valid_reg |-> state_reg == tcw_pkg::S_COPY)
        else $error("copy write outside scroll");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcw_pkg::S_IDLE |-> !cmd.we)
        else $error("store write while idle");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < tcw_pkg::ROWS && 32'(col_reg) < tcw_pkg::COLUMNS)
        else $error("cursor out of range");

    a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(base_reg) == 32'(row_reg) * tcw_pkg::COLUMNS)
        else $error("line base does not match cursor row");

    a_done_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == tcw_pkg::S_IDLE)
        else $error("result posted without return to idle");

endmodule

// File: src/text_console_writer.sv
// Text console writer on an 80x25 screen store; it handles put, clear and read items.
// A scroll copies CELLS-COLUMNS cells up a row, drains the last copy write, then fills
// the bottom row; a clear fills every cell with the text attribute and a space.
// Items: one at a time, next item taken once the result is registered.
// Reset: cursor home, attribute 7, then a clearing pass; no item before.
module text_console_writer
(
    input  logic   clk,
    input  logic   rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_rsp_if.source rsp,
    tcw_cfg_if.sink   cfg
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic [7:0]                 attr_reg;
    logic                       out_valid_reg;
    tcw_pkg::result_t           out_reg;
    tcw_pkg::result_t           result;
    tcw_pkg::mem_cmd_t          mem_cmd;
    logic                       seq_idle;
    logic                       seq_done;
    logic                       slot_free;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = seq_idle;
    assign cfg.ready = 1'b1;

    tcw_sequencer u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.valid && seq_idle),
        .op         (cmd.op),
        .char_code  (cmd.char_code),
        .cell_index (cmd.cell_index),
        .attr       (attr_reg),
        .rd_data    (rd_data_reg),
        .slot_free  (slot_free),
        .idle       (seq_idle),
        .done       (seq_done),
        .result     (result),
        .cmd        (mem_cmd)
    );

    always_ff @(posedge clk)
    begin
        if (mem_cmd.we)
        begin
            mem[mem_cmd.waddr] <= mem_cmd.wdata;
        end
        if (mem_cmd.re)
        begin
            rd_data_reg <= mem[mem_cmd.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                attr_reg <= cfg.data;
            end
            if (seq_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_data  = out_reg.cell_data;
    assign rsp.cursor_row = out_reg.cursor_row;
    assign rsp.cursor_col = out_reg.cursor_col;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> !out_valid_reg || rsp.ready)
        else $error("result register overwritten");

    a_busy_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |=> !cmd.ready || out_valid_reg)
        else $error("result lost after completion");

    a_no_access_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready && !cmd.valid |-> !mem_cmd.we && !mem_cmd.re)
        else $error("store access while waiting for an item");

endmodule

// File: verif/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: put, clear, read and unused-op items on
// the screen store, checked against an in-bench console predictor.
// Depends on tcw_pkg, the tcw_*_if interfaces and the text_console_writer RTL.
module text_console_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_PRINTED   = 40;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY4,
        RX_MOSTLY
    } rx_mode_t;

    logic clk;
    logic rst_n;

    tcw_cmd_if cmd_ch();
    tcw_rsp_if rsp_ch();
    tcw_cfg_if cfg_ch();

    text_console_writer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic [tcw_pkg::CELL_W-1:0] screen_model [tcw_pkg::CELLS];
    int                         cur_row;
    int                         cur_col;
    logic [7:0]                 text_attr;
    tcw_pkg::result_t           screen_replies [$];
    int                         error_count = 0;
    int                         burst_left;
    bit                         steady_send;
    bit                         rsp_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void scroll_screen();
        int i;
        for (i = 0; i + tcw_pkg::COLUMNS < tcw_pkg::CELLS; i++)
            screen_model[i] = screen_model[i + tcw_pkg::COLUMNS];
        for (i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
            screen_model[i] = {text_attr, tcw_pkg::CH_SPACE};
        cur_row = tcw_pkg::ROWS - 1;
    endfunction

    function automatic void advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= tcw_pkg::ROWS)
            scroll_screen();
    endfunction

    function automatic void place_glyph(input logic [tcw_pkg::CHAR_W-1:0] ch);
        int pos;
        pos = cur_row * tcw_pkg::COLUMNS + cur_col;
        if (pos < tcw_pkg::CELLS)
            screen_model[pos] = {text_attr, ch};
        cur_col++;
        if (cur_col >= tcw_pkg::COLUMNS)
            advance_line();
    endfunction

    function automatic tcw_pkg::result_t console_apply(
        input logic [tcw_pkg::OP_W-1:0]    op,
        input logic [tcw_pkg::CHAR_W-1:0]  ch,
        input logic [tcw_pkg::INDEX_W-1:0] idx);
        tcw_pkg::result_t r;
        int               i;
        r = '0;
        case (op)
            tcw_pkg::OP_PUT:
            begin
                if (ch == tcw_pkg::CH_NEWLINE)
                    advance_line();
                else if (ch == tcw_pkg::CH_RETURN)
                    cur_col = 0;
                else if (ch == tcw_pkg::CH_TAB)
                    repeat (tcw_pkg::TAB_SPACES) place_glyph(tcw_pkg::CH_SPACE);
                else
                    place_glyph(ch);
            end
            tcw_pkg::OP_CLEAR:
            begin
                for (i = 0; i < tcw_pkg::CELLS; i++)
                    screen_model[i] = {text_attr, tcw_pkg::CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            tcw_pkg::OP_READ:
            begin
                if (idx < tcw_pkg::CELLS)
                    r.cell_data = screen_model[idx];
            end
            default:
            begin
            end
        endcase
        r.cursor_row = tcw_pkg::RES_ROW_W'(cur_row);
        r.cursor_col = tcw_pkg::RES_COL_W'(cur_col);
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic send_item(input logic [tcw_pkg::OP_W-1:0] op,
                             input logic [tcw_pkg::CHAR_W-1:0] ch,
                             input logic [tcw_pkg::INDEX_W-1:0] idx);
        int gap;
        if (!steady_send && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            cmd_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        cmd_ch.valid      = 1'b1;
        cmd_ch.op         = op;
        cmd_ch.char_code  = ch;
        cmd_ch.cell_index = idx;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        screen_replies.push_back(console_apply(op, ch, idx));
    endtask

    task automatic drain_replies();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (screen_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_text_attr(input logic [7:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        text_attr = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_random_item(input int nl_pct, input int clear_pm);
        int                            roll;
        int                            here;
        logic [tcw_pkg::CHAR_W-1:0]    ch;
        logic [tcw_pkg::INDEX_W-1:0]   idx;
        roll = $urandom_range(0, 999);
        ch   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        idx  = tcw_pkg::INDEX_W'($urandom_range(0, 2047));
        if (roll < clear_pm)
            send_item(tcw_pkg::OP_CLEAR, ch, idx);
        else if (roll < clear_pm + 20)
            send_item(OP_UNUSED, ch, idx);
        else if (roll < clear_pm + 240)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                here = cur_row * tcw_pkg::COLUMNS + cur_col;
                idx  = (here == 0) ? '0 : tcw_pkg::INDEX_W'(here - 1);
            end
            send_item(tcw_pkg::OP_READ, ch, idx);
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < nl_pct)
                ch = tcw_pkg::CH_NEWLINE;
            else if (roll < nl_pct + 5)
                ch = tcw_pkg::CH_RETURN;
            else if (roll < nl_pct + 12)
                ch = tcw_pkg::CH_TAB;
            send_item(tcw_pkg::OP_PUT, ch, idx);
        end
    endtask

    task automatic run_text_phase(input logic [7:0] attr, input int nl_pct,
                                  input int clear_pm, input int count);
        int n;
        drain_replies();
        write_text_attr(attr);
        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                steady_send = ($urandom_range(0, 3) == 0);
            send_random_item(nl_pct, clear_pm);
        end
        steady_send = 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'hFF, tcw_pkg::INDEX_W'(tcw_pkg::CELLS - 1));
        send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::CELLS));
        send_item(tcw_pkg::OP_READ, 8'h00, 11'h7FF);
        send_item(OP_UNUSED, 8'hFF, 11'h7FF);
    endtask

    task automatic test_control_chars();
        send_item(tcw_pkg::OP_PUT, 8'h48, 11'h000);
        send_item(tcw_pkg::OP_PUT, 8'h00, 11'h7FF);
        send_item(tcw_pkg::OP_PUT, 8'hFF, 11'h000);
        send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
        send_item(tcw_pkg::OP_READ, 8'h00, 11'd2);
        send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 11'h000);
        send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 11'h000);
        send_item(tcw_pkg::OP_READ, 8'h00, 11'd1);
        send_item(OP_UNUSED, 8'h00, 11'h000);
        send_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'h000);
        send_item(tcw_pkg::OP_READ, 8'h00, 11'd3);
    endtask

    task automatic test_attribute_writes();
        drain_replies();
        write_text_attr(8'hFF);
        send_item(tcw_pkg::OP_PUT, 8'h5A, 11'h000);
        send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::COLUMNS));
        drain_replies();
        write_text_attr(8'h00);
        send_item(tcw_pkg::OP_CLEAR, 8'h00, 11'h000);
        send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::CELLS - 1));
        send_item(tcw_pkg::OP_PUT, 8'h71, 11'h000);
        send_item(tcw_pkg::OP_READ, 8'h00, 11'd0);
        drain_replies();
        write_text_attr(tcw_pkg::ATTR_RESET);
    endtask

    // hold the result side off while items keep coming
    task automatic test_output_stall();
        int n;
        drain_replies();
        rsp_hold_req = 1'b1;
        steady_send  = 1'b1;
        for (n = 0; n < 12; n++)
            send_item(tcw_pkg::OP_PUT, 8'h41 + 8'(n), 11'h000);
        steady_send = 1'b0;
        drain_replies();
    endtask

    task automatic test_random_text();
        run_text_phase(8'h1F, 2, 0, 350);
        run_text_phase(8'h00, 15, 0, 350);
        run_text_phase(8'hFF, 8, 8, 350);
        run_text_phase(8'($urandom_range(0, 255)), 4, 3, 350);
    endtask

    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        int       hold_left;
        rsp_ch.ready = 1'b0;
        mode         = RX_OPEN;
        mode_left    = 0;
        tick         = 0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && rsp_hold_req)
            begin
                hold_left    = HOLD_CYCLES;
                rsp_hold_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:   rsp_ch.ready = 1'b1;
                    RX_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
                    RX_EVERY4: rsp_ch.ready = (tick % 4 == 0);
                    default:   rsp_ch.ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial
    begin
        tcw_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (screen_replies.size() == 0)
                    report_error("result with no item waiting");
                else
                begin
                    want = screen_replies.pop_front();
                    if (rsp_ch.cell_data !== want.cell_data)
                        report_error($sformatf("cell_data got %h want %h",
                                               rsp_ch.cell_data, want.cell_data));
                    if (rsp_ch.cursor_row !== want.cursor_row)
                        report_error($sformatf("cursor_row got %0d want %0d",
                                               rsp_ch.cursor_row, want.cursor_row));
                    if (rsp_ch.cursor_col !== want.cursor_col)
                        report_error($sformatf("cursor_col got %0d want %0d",
                                               rsp_ch.cursor_col, want.cursor_col));
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("text_console_writer regression: fail");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = tcw_pkg::OP_PUT;
        cmd_ch.char_code  = '0;
        cmd_ch.cell_index = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        burst_left        = 0;
        steady_send       = 1'b0;
        rsp_hold_req      = 1'b0;
        foreach (screen_model[i])
            screen_model[i] = tcw_pkg::RESET_CELL;
        cur_row   = 0;
        cur_col   = 0;
        text_attr = tcw_pkg::ATTR_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_control_chars();
        test_attribute_writes();
        test_output_stall();
        test_random_text();

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && screen_replies.size() == 0)
            $display("text_console_writer regression: pass");
        else
            $display("text_console_writer regression: fail");
        $finish;
    end

endmodule
